[hw/rtl/sfc_pkg.sv]
// Shared types, constants and CRC helper for the serial frame checker.
package sfc_pkg;

  localparam logic [7:0]  START0_BYTE  = 8'hA5;
  localparam logic [7:0]  START1_BYTE  = 8'h5A;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned CRC_BYTES    = 2;

  // byte positions inside the header
  localparam logic [15:0] POS_START0 = 16'd0;
  localparam logic [15:0] POS_START1 = 16'd1;
  localparam logic [15:0] POS_DEST   = 16'd2;
  localparam logic [15:0] POS_SOURCE = 16'd3;
  localparam logic [15:0] POS_SEQ    = 16'd4;
  localparam logic [15:0] POS_CMD    = 16'd5;
  localparam logic [15:0] POS_LEN_LO = 16'd6;
  localparam logic [15:0] POS_LEN_HI = 16'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_LOCAL_ADDR = 2'd0;
  localparam logic [1:0] CFG_PEER_ADDR  = 2'd1;
  localparam logic [1:0] CFG_EXP_CMD    = 2'd2;
  localparam logic [1:0] CFG_EXP_SEQ    = 2'd3;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_BAD_START = 3'd2,
    VERDICT_ADDRESS   = 3'd3,
    VERDICT_SEQ_CMD   = 3'd4,
    VERDICT_TRUNCATED = 3'd5,
    VERDICT_CRC       = 3'd6,
    VERDICT_STATUS    = 3'd7
  } verdict_t;

  typedef struct packed {
    logic [7:0] local_address;
    logic [7:0] peer_address;
    logic [7:0] expected_command;
    logic [7:0] expected_sequence;
  } sfc_cfg_t;

  typedef struct packed {
    logic [7:0]  status_byte;
    logic [15:0] payload_length;
    logic [7:0]  frame_sequence;
    logic [7:0]  frame_command;
    verdict_t    verdict;
  } sfc_result_t;

  // CRC-16/MODBUS update with one byte, reflected
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/sfc_frame_track.sv]
// Per-frame state: header capture, running CRC, byte count and verdict.
module sfc_frame_track
  import sfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,       // registered beat is consumed this cycle
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  input  sfc_cfg_t    cfg,
  output sfc_result_t res         // valid when step && frame_end
);

  logic [15:0] byte_count_r, byte_count_nxt, byte_count_upd;
  logic [15:0] crc_running_r, crc_running_nxt, crc_running_upd;
  logic [15:0] crc_end_r, crc_end_nxt, crc_end_upd;
  logic [15:0] crc_rx_r, crc_rx_nxt, crc_rx_upd;
  logic        start_ok_r, start_ok_nxt, start_ok_upd;
  logic [7:0]  dest_r, dest_nxt, dest_upd;
  logic [7:0]  source_r, source_nxt, source_upd;
  logic [7:0]  seq_r, seq_nxt, seq_upd;
  logic [7:0]  cmd_r, cmd_nxt, cmd_upd;
  logic [15:0] length_r, length_nxt, length_upd;
  logic [7:0]  first_r, first_nxt, first_upd;

  logic [16:0] pay_end;
  logic [16:0] idx_plus1;
  logic [17:0] need;
  logic        in_header;

  always_comb begin
    byte_count_upd  = byte_count_r;
    crc_running_upd = crc_running_r;
    crc_end_upd     = crc_end_r;
    crc_rx_upd      = crc_rx_r;
    start_ok_upd    = start_ok_r;
    dest_upd        = dest_r;
    source_upd      = source_r;
    seq_upd         = seq_r;
    cmd_upd         = cmd_r;
    length_upd      = length_r;
    first_upd       = first_r;
    in_header       = byte_count_r < 16'(HEADER_BYTES);
    idx_plus1       = {1'b0, byte_count_r} + 17'd1;
    pay_end         = 17'(HEADER_BYTES) + {1'b0, length_r};

    if (byte_count_r != COUNT_MAX) begin
      unique case (byte_count_r)
        POS_START0: start_ok_upd = (rx_byte == START0_BYTE);
        POS_START1: start_ok_upd = start_ok_r && (rx_byte == START1_BYTE);
        POS_DEST:   dest_upd     = rx_byte;
        POS_SOURCE: source_upd   = rx_byte;
        POS_SEQ:    seq_upd      = rx_byte;
        POS_CMD:    cmd_upd      = rx_byte;
        POS_LEN_LO: length_upd   = {length_r[15:8], rx_byte};
        POS_LEN_HI: length_upd   = {rx_byte, length_r[7:0]};
        default: ;
      endcase
      // payload end uses the length as just updated
      pay_end = 17'(HEADER_BYTES) + {1'b0, length_upd};

      if (byte_count_r >= POS_DEST && (in_header || {1'b0, byte_count_r} < pay_end)) begin
        crc_running_upd = crc_feed(crc_running_r, rx_byte);
        if (idx_plus1 == pay_end) begin
          crc_end_upd = crc_running_upd;
        end
      end
      if (byte_count_r == 16'(HEADER_BYTES) && length_upd != 16'd0) begin
        first_upd = rx_byte;
      end
      if (!in_header && {1'b0, byte_count_r} == pay_end) begin
        crc_rx_upd = {crc_rx_r[15:8], rx_byte};
      end
      if (!in_header && {2'b00, byte_count_r} == {1'b0, pay_end} + 18'd1) begin
        crc_rx_upd = {rx_byte, crc_rx_upd[7:0]};
      end
      byte_count_upd = byte_count_r + 16'd1;
    end

    need = 18'(HEADER_BYTES + CRC_BYTES) + {2'b00, length_upd};

    priority if (byte_count_upd < 16'(HEADER_BYTES + CRC_BYTES)) begin
      res.verdict = VERDICT_SHORT;
    end else if (!start_ok_upd) begin
      res.verdict = VERDICT_BAD_START;
    end else if (dest_upd != cfg.local_address || source_upd != cfg.peer_address) begin
      res.verdict = VERDICT_ADDRESS;
    end else if (seq_upd != cfg.expected_sequence || cmd_upd != cfg.expected_command) begin
      res.verdict = VERDICT_SEQ_CMD;
    end else if ({2'b00, byte_count_upd} < need) begin
      res.verdict = VERDICT_TRUNCATED;
    end else if (crc_rx_upd != crc_end_upd) begin
      res.verdict = VERDICT_CRC;
    end else if (length_upd != 16'd0 && first_upd != 8'd0) begin
      res.verdict = VERDICT_STATUS;
    end else begin
      res.verdict = VERDICT_OK;
    end
    res.frame_command  = cmd_upd;
    res.frame_sequence = seq_upd;
    res.payload_length = length_upd;
    res.status_byte    = (length_upd != 16'd0) ? first_upd : 8'd0;

    // next state: hold, advance, or clear after the last beat of a frame
    byte_count_nxt  = byte_count_r;
    crc_running_nxt = crc_running_r;
    crc_end_nxt     = crc_end_r;
    crc_rx_nxt      = crc_rx_r;
    start_ok_nxt    = start_ok_r;
    dest_nxt        = dest_r;
    source_nxt      = source_r;
    seq_nxt         = seq_r;
    cmd_nxt         = cmd_r;
    length_nxt      = length_r;
    first_nxt       = first_r;
    if (step && frame_end) begin
      byte_count_nxt  = 16'd0;
      crc_running_nxt = CRC_INIT;
      crc_end_nxt     = 16'd0;
      crc_rx_nxt      = 16'd0;
      start_ok_nxt    = 1'b1;
      dest_nxt        = 8'd0;
      source_nxt      = 8'd0;
      seq_nxt         = 8'd0;
      cmd_nxt         = 8'd0;
      length_nxt      = 16'd0;
      first_nxt       = 8'd0;
    end else if (step) begin
      byte_count_nxt  = byte_count_upd;
      crc_running_nxt = crc_running_upd;
      crc_end_nxt     = crc_end_upd;
      crc_rx_nxt      = crc_rx_upd;
      start_ok_nxt    = start_ok_upd;
      dest_nxt        = dest_upd;
      source_nxt      = source_upd;
      seq_nxt         = seq_upd;
      cmd_nxt         = cmd_upd;
      length_nxt      = length_upd;
      first_nxt       = first_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= 16'd0;
      crc_running_r <= CRC_INIT;
      crc_end_r     <= 16'd0;
      crc_rx_r      <= 16'd0;
      start_ok_r    <= 1'b1;
      dest_r        <= 8'd0;
      source_r      <= 8'd0;
      seq_r         <= 8'd0;
      cmd_r         <= 8'd0;
      length_r      <= 16'd0;
      first_r       <= 8'd0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      crc_running_r <= crc_running_nxt;
      crc_end_r     <= crc_end_nxt;
      crc_rx_r      <= crc_rx_nxt;
      start_ok_r    <= start_ok_nxt;
      dest_r        <= dest_nxt;
      source_r      <= source_nxt;
      seq_r         <= seq_nxt;
      cmd_r         <= cmd_nxt;
      length_r      <= length_nxt;
      first_r       <= first_nxt;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && frame_end |=> byte_count_r == 16'd0 && crc_running_r == CRC_INIT)
    else $error("frame state not cleared after last beat");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    step && !frame_end |=> byte_count_r >= $past(byte_count_r))
    else $error("byte count went backwards inside a frame");

  a_crc_idle_in_start: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= POS_DEST |-> crc_running_r == CRC_INIT)
    else $error("CRC moved during start bytes");

endmodule

[hw/rtl/serial_frame_checker_crc16.sv]
// Top level of the serial frame checker: stream ports, config registers, beat and result regs.
// Frame checker for A5 5A framed packets with a CRC-16/MODBUS trailer. One byte beat is
// accepted every clock while in_tready is high; the beat is registered, then the frame state
// (header capture, CRC over destination through payload, saturating byte count) is updated
// from the beat register when the beat is consumed, and on the beat flagged in_tlast the
// verdict goes to the result register, which drives out_*. Input only stalls when a last byte
// is waiting in the beat register and the previous verdict has not yet been taken on out_*.
// Configuration (addresses, expected command and sequence) is written through cfg_*; the user
// must write it only while no frame is in flight, which the block itself does not enforce.
module serial_frame_checker_crc16
  import sfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] verdict, [10:3] frame_command, [18:11] frame_sequence,
  // [34:19] payload_length, [42:35] status_byte, [47:43] zero
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  sfc_cfg_t    cfg_r;
  logic        beat_vld_r;
  logic [7:0]  beat_byte_r;
  logic        beat_last_r;
  logic        out_vld_r;
  sfc_result_t out_res_r;
  sfc_result_t res;
  logic        step;

  // a non-final beat never needs the result slot
  assign step      = beat_vld_r && (!beat_last_r || !out_vld_r || out_tready);
  assign in_tready = !beat_vld_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_address     <= 8'd1;
      cfg_r.peer_address      <= 8'd2;
      cfg_r.expected_command  <= 8'd129;
      cfg_r.expected_sequence <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LOCAL_ADDR: cfg_r.local_address     <= cfg_wdata;
        CFG_PEER_ADDR:  cfg_r.peer_address      <= cfg_wdata;
        CFG_EXP_CMD:    cfg_r.expected_command  <= cfg_wdata;
        CFG_EXP_SEQ:    cfg_r.expected_sequence <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_vld_r <= 1'b0;
    end else if (in_tready) begin
      beat_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      beat_byte_r <= in_tdata;
      beat_last_r <= in_tlast;
    end
  end

  sfc_frame_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (beat_byte_r),
    .frame_end (beat_last_r),
    .cfg       (cfg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step && beat_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && beat_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_res_r};

endmodule
